// ===== sv/dopf_pkg.sv =====
package dopf_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN   = 24;
  localparam int ITERS  = (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ? ANGLE_ITERATIONS
                                                               : ATAN_TABLE_LEN;
  localparam int CNT_W  = $clog2(ITERS);

  localparam int IN_W   = 264;
  localparam int OUT_W  = 184;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PRESENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION    = 2'd2;

  localparam logic [9:0] SEPARATION_RESET = 10'd100;

  localparam logic [2:0] FLD_X    = 3'd0;
  localparam logic [2:0] FLD_Y    = 3'd1;
  localparam logic [2:0] FLD_VX   = 3'd2;
  localparam logic [2:0] FLD_VY   = 3'd3;
  localparam logic [2:0] FLD_RATE = 3'd4;
  localparam logic [2:0] FLD_SLIP = 3'd5;

  localparam logic [16:0] LIN_GAIN  = 17'd125;
  localparam logic [16:0] RATE_GAIN = 17'd36602;

  // CORDIC datapath widths: x and y reach about 2^36, angle about 2^23
  localparam int CW = 39;
  localparam int ZW = 25;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [23:0] left_pos_x;
    logic signed [23:0] left_pos_y;
    logic signed [15:0] left_heading;
    logic signed [23:0] left_vel_x;
    logic signed [23:0] left_vel_y;
    logic signed [18:0] left_turn_rate;
    logic signed [23:0] right_pos_x;
    logic signed [23:0] right_pos_y;
    logic signed [15:0] right_heading;
    logic signed [23:0] right_vel_x;
    logic signed [23:0] right_vel_y;
    logic signed [18:0] right_turn_rate;
  } in_item_t;

  function automatic logic [22:0] atan_q16(input logic [4:0] i);
    logic [22:0] v;
    unique case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/dual_odometry_pose_fusion.sv =====
// Fuses one tick item from a left and a right odometry sensor into one pose item.
// An item is taken when the block is idle; it then runs through ST_RUN, in which
// a single CORDIC stage iterates the heading arctangent one rotation per
// cycle while a shared scale unit converts one field per cycle, then through
// ST_DONE, which hands the result to the output register once that register is
// free, so a new item is taken only after the last one is handed on. The output
// register holds a finished item while the next one is already taken in.
module dual_odometry_pose_fusion (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_pos_x, left_pos_y, left_heading, left_vel_x, left_vel_y,
  // left_turn_rate, right_pos_x, right_pos_y, right_heading, right_vel_x,
  // right_vel_y, right_turn_rate, zero pad
  input  logic [dopf_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fused_x, fused_y, fused_heading, fused_vel_x, fused_vel_y,
  // fused_turn_rate, slip, tick_number, zero pad
  output logic [dopf_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [dopf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dopf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dopf_pkg::*;

  state_t state, state_next;

  logic       left_present, right_present;
  logic [9:0] separation_mm;

  in_item_t   item;
  logic [CNT_W-1:0] cnt;

  logic signed [21:0] held_x, held_y, held_vel_x, held_vel_y;
  logic signed [15:0] held_heading;
  logic signed [18:0] held_turn_rate;
  logic [21:0]        slip;
  logic [31:0]        tick_counter;

  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 dy_zero;

  logic accept, load_out, step_last;
  logic both, any;

  in_item_t             in_item;
  logic signed [24:0]   dy_in;
  logic signed [CW-1:0] cy_init;

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;

  logic signed [23:0] opa, opb;
  logic signed [24:0] sum, diff, diff_abs;
  logic signed [25:0] op;
  logic               is_rate;
  logic signed [42:0] prod, rnd, res;

  logic signed [ZW-1:0] z_rnd;
  logic signed [15:0]   heading_new;

  assign both = left_present & right_present;
  assign any  = left_present | right_present;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_RUN;
      ST_RUN:  if (step_last) state_next = ST_DONE;
      ST_DONE: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RUN:  ;
      ST_DONE: load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign step_last = (cnt == CNT_W'(ITERS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_present  <= 1'b0;
      right_present <= 1'b0;
      separation_mm <= SEPARATION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_PRESENT:  left_present  <= cfg_data[0];
        CFG_RIGHT_PRESENT: right_present <= cfg_data[0];
        CFG_SEPARATION:    separation_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the slave item, first field in the lowest bits
  always_comb begin
    in_item.left_pos_x      = s_axis_tdata[23:0];
    in_item.left_pos_y      = s_axis_tdata[47:24];
    in_item.left_heading    = s_axis_tdata[63:48];
    in_item.left_vel_x      = s_axis_tdata[87:64];
    in_item.left_vel_y      = s_axis_tdata[111:88];
    in_item.left_turn_rate  = s_axis_tdata[130:112];
    in_item.right_pos_x     = s_axis_tdata[154:131];
    in_item.right_pos_y     = s_axis_tdata[178:155];
    in_item.right_heading   = s_axis_tdata[194:179];
    in_item.right_vel_x     = s_axis_tdata[218:195];
    in_item.right_vel_y     = s_axis_tdata[242:219];
    in_item.right_turn_rate = s_axis_tdata[261:243];
  end

  assign dy_in   = 25'(in_item.right_pos_y) - 25'(in_item.left_pos_y);
  assign cy_init = CW'(dy_in) * CW'(signed'(11'd1000));

  // CORDIC vectoring, one rotation per cycle
  assign xs  = cx >>> cnt;
  assign ys  = cy >>> cnt;
  assign ang = ZW'(atan_q16(5'(cnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == ST_RUN) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_item;
      cx      <= CW'({separation_mm, 16'd0});
      cy      <= cy_init;
      cz      <= '0;
      dy_zero <= (dy_in == 25'sd0);
    end else if (state == ST_RUN) begin
      if (!cy[CW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + ang;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - ang;
      end
    end
  end

  // shared scale unit: one field per cycle, avg and single both as (2-term sum)
  always_comb begin
    opa     = item.left_pos_x;
    opb     = item.right_pos_x;
    is_rate = 1'b0;
    unique case (3'(cnt))
      FLD_X: begin
        opa = item.left_pos_x;
        opb = item.right_pos_x;
      end
      FLD_Y: begin
        opa = item.left_pos_y;
        opb = item.right_pos_y;
      end
      FLD_VX: begin
        opa = item.left_vel_x;
        opb = item.right_vel_x;
      end
      FLD_VY: begin
        opa = item.left_vel_y;
        opb = item.right_vel_y;
      end
      FLD_RATE: begin
        opa     = 24'(item.left_turn_rate);
        opb     = 24'(item.right_turn_rate);
        is_rate = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum      = 25'(opa) + 25'(opb);
  assign diff     = 25'(item.right_pos_x) - 25'(item.left_pos_x);
  assign diff_abs = diff[24] ? -diff : diff;

  always_comb begin
    if (3'(cnt) == FLD_SLIP) begin
      op = {diff_abs, 1'b0};
    end else if (both) begin
      op = 26'(sum);
    end else if (left_present) begin
      op = {opa[23], opa, 1'b0};
    end else begin
      op = {opb[23], opb, 1'b0};
    end
  end

  assign prod = 43'(op) * 43'(signed'({1'b0, is_rate ? RATE_GAIN : LIN_GAIN}));
  assign rnd  = prod + (is_rate ? 43'sd65536 : 43'sd512);
  assign res  = is_rate ? (rnd >>> 17) : (rnd >>> 10);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x         <= '0;
      held_y         <= '0;
      held_vel_x     <= '0;
      held_vel_y     <= '0;
      held_turn_rate <= '0;
      held_heading   <= '0;
      slip           <= '0;
      tick_counter   <= '0;
    end else begin
      if (accept) begin
        tick_counter <= tick_counter + 32'd1;
        slip         <= '0;
      end
      if (state == ST_RUN && any && cnt < CNT_W'(6)) begin
        unique case (3'(cnt))
          FLD_X:    held_x         <= res[21:0];
          FLD_Y:    held_y         <= res[21:0];
          FLD_VX:   held_vel_x     <= res[21:0];
          FLD_VY:   held_vel_y     <= res[21:0];
          FLD_RATE: held_turn_rate <= res[18:0];
          FLD_SLIP: if (both) slip <= res[21:0];
          default: ;
        endcase
      end
      if (load_out) begin
        held_heading <= heading_new;
      end
    end
  end

  assign z_rnd = cz + ZW'(256);

  always_comb begin
    if (both) begin
      heading_new = dy_zero ? 16'sd0 : 16'(z_rnd >>> 9);
    end else if (left_present) begin
      heading_new = item.left_heading;
    end else if (right_present) begin
      heading_new = item.right_heading;
    end else begin
      heading_new = held_heading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {7'd0, tick_counter, slip, held_turn_rate, held_vel_y,
                       held_vel_x, heading_new, held_y, held_x};
    end
  end

endmodule
